// ===== hdl/ppu_pkg.sv =====
// Shared types and codes of the particle pool update core.
`default_nettype none
package ppu_pkg;

    localparam int SLOT_W = 5;

    localparam logic [1:0] FUNC_EMIT  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] KIND_EMIT  = 2'd0;
    localparam logic [1:0] KIND_UPD   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] CFG_GRAVITY   = 2'd0;
    localparam logic [1:0] CFG_POOL_SIZE = 2'd1;
    localparam logic [1:0] CFG_FLOOR     = 2'd2;

    localparam logic [31:0] GRAVITY_RST = 32'h0000_0000;
    localparam logic [5:0]  POOL_RST    = 6'd32;
    localparam logic [31:0] FLOOR_RST   = 32'hFFF6_0000;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [15:0] age;
        logic [15:0] life;
        logic [15:0] scale_start;
        logic [15:0] scale_end;
    } t_slot;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic              accepted;
        logic [31:0]       out_x;
        logic [31:0]       out_y;
        logic [31:0]       out_z;
        logic [15:0]       out_scale;
        logic              expired;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/particle_pool_update_core.sv =====
// Particle pool update core: slot store, emit search and per-slot tick sequencer.
//
// Input channel (s_axis): tuser carries func (emit, tick, clear), tdata carries the
// emit fields. Output channel (m_axis): tuser carries kind, tlast marks the final
// result of an input transaction. Configuration is written through a plain write
// port; the user must write it only while the block is idle, which the block itself
// does not enforce. An input transaction is taken only while the sequencer is idle;
// one item is in flight at a time. Clear and unused codes go straight to the push
// state. An emit first reduces the hint into the pool by repeated subtraction if the
// pool shrank and then probes one slot per cycle. A tick scans one slot per cycle;
// each active slot adds a memory read, four passes through the shared saturating
// adder, two passes through the 16x16 multiplier and a 16-step restoring divider for
// the scale, the divider being skipped with a zero lifetime. Results wait in one
// output register; a stalled receiver holds the sequencer at its next result. Reset
// clears the active bits, the hint, the output valid flag and loads the configuration
// defaults; slot contents are not cleared.
`default_nettype none
module particle_pool_update_core #(
    parameter int POOL_DEPTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wen,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, lifetime, scale_start, scale_end
    input  wire logic [239:0] s_axis_tdata,
    // func
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // slot, accepted, out_x, out_y, out_z, out_scale, expired, zero pad
    output logic [119:0]      m_axis_tdata,
    // kind
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int AW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CAP = (POOL_DEPTH < 32) ? POOL_DEPTH : 32;
    localparam int SW  = ppu_pkg::SLOT_W;
    localparam int RW  = $bits(ppu_pkg::t_result);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_ESRCH = 4'd2;
    localparam logic [3:0] S_TSCAN = 4'd3;
    localparam logic [3:0] S_TRD   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_MUL0  = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_DIVI  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_PUSH  = 4'd11;

    logic [31:0] r_gravity;
    logic [5:0]  r_pool_size;
    logic [31:0] r_floor;

    logic [3:0]  r_state;
    logic [3:0]  r_nxt;
    logic [POOL_DEPTH-1:0] r_active;
    logic [SW-1:0] r_hint;
    logic [SW-1:0] r_idx;
    logic [5:0]  r_cnt;
    logic [5:0]  r_i;
    logic [1:0]  r_astep;
    logic [3:0]  r_dcnt;
    logic        r_any;

    ppu_pkg::t_slot   r_in;
    ppu_pkg::t_slot   r_w;
    ppu_pkg::t_slot   n_w;
    ppu_pkg::t_slot   r_rd;
    ppu_pkg::t_result r_res;
    ppu_pkg::t_result r_out;
    logic             r_ov;
    logic [31:0] r_acc;
    logic [15:0] r_rem;
    logic [15:0] r_q;

    ppu_pkg::t_slot mem [POOL_DEPTH];

    logic [5:0]  w_n;
    logic        w_out_free;
    logic [SW-1:0] w_idx_inc;
    logic [1:0]  w_kind0;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic        w_sub;
    logic [32:0] w_sum;
    logic [31:0] n_sat;
    logic [15:0] w_ac;
    logic [31:0] w_prod;
    logic [16:0] w_trial;
    logic        w_later;
    logic        w_exp;
    logic [31:0] w_num;

    assign w_n = (r_pool_size > 6'(CAP)) ? 6'(CAP) : r_pool_size;
    assign w_out_free = !r_ov || m_axis_tready;
    assign w_idx_inc = ({1'b0, r_idx} + 6'd1 == w_n) ? '0 : r_idx + 1'b1;
    assign w_kind0 = (s_axis_tuser == ppu_pkg::FUNC_EMIT) ? ppu_pkg::KIND_EMIT
                                                           : ppu_pkg::KIND_EMPTY;

    // shared saturating adder: vy - g, then px + vx, py + vy, pz + vz
    always_comb begin
        w_sub = 1'b0;
        case (r_astep)
            2'd0: begin
                w_a = r_w.vel_y;
                w_b = r_gravity;
                w_sub = 1'b1;
            end
            2'd1: begin
                w_a = r_w.pos_x;
                w_b = r_w.vel_x;
            end
            2'd2: begin
                w_a = r_w.pos_y;
                w_b = r_w.vel_y;
            end
            default: begin
                w_a = r_w.pos_z;
                w_b = r_w.vel_z;
            end
        endcase
        w_sum = w_sub ? ({w_a[31], w_a} - {w_b[31], w_b}) : ({w_a[31], w_a} + {w_b[31], w_b});
        if (w_sum[32] != w_sum[31]) begin
            n_sat = w_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            n_sat = w_sum[31:0];
        end
    end

    // age the slot as it is loaded, holding at the top
    always_comb begin
        n_w = r_rd;
        if (r_rd.age != 16'hFFFF) begin
            n_w.age = r_rd.age + 16'd1;
        end
    end

    assign w_ac = (r_w.age > r_w.life) ? r_w.life : r_w.age;
    assign w_prod = (r_state == S_MUL0) ? 32'(r_w.scale_start) * 32'(r_w.life - w_ac)
                                        : 32'(r_w.scale_end) * 32'(w_ac);
    assign w_trial = {r_rem, r_q[15]};
    assign w_num = r_acc + 32'(r_w.life[15:1]);
    assign w_exp = (r_w.age >= r_w.life) || ($signed(r_w.pos_y) < $signed(r_floor));

    always_comb begin
        w_later = 1'b0;
        for (int j = 0; j < POOL_DEPTH; j++) begin
            if (r_active[j] && (7'(j) > {1'b0, r_i}) && (7'(j) < {1'b0, w_n})) begin
                w_later = 1'b1;
            end
        end
    end

    // slot memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_ESRCH && !r_active[AW'(r_idx)]) begin
            mem[AW'(r_idx)] <= r_in;
        end else if (r_state == S_FIN) begin
            mem[AW'(r_i)] <= r_w;
        end
        if (r_state == S_TSCAN) begin
            r_rd <= mem[AW'(r_i)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= ppu_pkg::GRAVITY_RST;
            r_pool_size <= ppu_pkg::POOL_RST;
            r_floor     <= ppu_pkg::FLOOR_RST;
            r_state     <= S_IDLE;
            r_nxt       <= S_IDLE;
            r_active    <= '0;
            r_hint      <= '0;
            r_ov        <= 1'b0;
            r_any       <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    ppu_pkg::CFG_GRAVITY:   r_gravity <= i_cfg_wdata;
                    ppu_pkg::CFG_POOL_SIZE: r_pool_size <= i_cfg_wdata[5:0];
                    ppu_pkg::CFG_FLOOR:     r_floor <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_PUSH && w_out_free) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in.pos_x       <= s_axis_tdata[31:0];
                        r_in.pos_y       <= s_axis_tdata[63:32];
                        r_in.pos_z       <= s_axis_tdata[95:64];
                        r_in.vel_x       <= s_axis_tdata[127:96];
                        r_in.vel_y       <= s_axis_tdata[159:128];
                        r_in.vel_z       <= s_axis_tdata[191:160];
                        r_in.age         <= 16'd0;
                        r_in.life        <= s_axis_tdata[207:192];
                        r_in.scale_start <= s_axis_tdata[223:208];
                        r_in.scale_end   <= s_axis_tdata[239:224];
                        r_res   <= {w_kind0, {(RW-3){1'b0}}, 1'b1};
                        r_nxt   <= S_IDLE;
                        r_idx   <= r_hint;
                        r_cnt   <= '0;
                        r_i     <= '0;
                        r_any   <= 1'b0;
                        case (s_axis_tuser)
                            ppu_pkg::FUNC_EMIT: begin
                                r_state <= (w_n == 6'd0) ? S_PUSH : S_MOD;
                            end
                            ppu_pkg::FUNC_TICK: begin
                                r_state <= S_TSCAN;
                            end
                            ppu_pkg::FUNC_CLEAR: begin
                                r_active <= '0;
                                r_hint <= '0;
                                r_state <= S_PUSH;
                            end
                            default: begin
                                r_state <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    // reduce the hint into the pool by repeated subtraction
                    if ({1'b0, r_idx} >= w_n) begin
                        r_idx <= r_idx - w_n[SW-1:0];
                    end else begin
                        r_state <= S_ESRCH;
                    end
                end
                S_ESRCH: begin
                    if (!r_active[AW'(r_idx)]) begin
                        r_active[AW'(r_idx)] <= 1'b1;
                        r_hint <= w_idx_inc;
                        r_res.slot <= r_idx;
                        r_res.accepted <= 1'b1;
                        r_res.out_x <= r_in.pos_x;
                        r_res.out_y <= r_in.pos_y;
                        r_res.out_z <= r_in.pos_z;
                        r_res.out_scale <= r_in.scale_start;
                        r_state <= S_PUSH;
                    end else if (r_cnt + 6'd1 == w_n) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                        r_idx <= w_idx_inc;
                    end
                end
                S_TSCAN: begin
                    if (r_i == w_n) begin
                        r_state <= r_any ? S_IDLE : S_PUSH;
                    end else if (r_active[AW'(r_i)]) begin
                        r_state <= S_TRD;
                    end else begin
                        r_i <= r_i + 6'd1;
                    end
                end
                S_TRD: begin
                    r_w <= n_w;
                    r_astep <= 2'd0;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    case (r_astep)
                        2'd0: r_w.vel_y <= n_sat;
                        2'd1: r_w.pos_x <= n_sat;
                        2'd2: r_w.pos_y <= n_sat;
                        default: r_w.pos_z <= n_sat;
                    endcase
                    r_astep <= r_astep + 2'd1;
                    if (r_astep == 2'd3) begin
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_acc <= w_prod;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_acc <= r_acc + w_prod;
                    r_state <= S_DIVI;
                end
                S_DIVI: begin
                    if (r_w.life == 16'd0) begin
                        r_q <= r_w.scale_end;
                        r_state <= S_FIN;
                    end else begin
                        r_rem <= w_num[31:16];
                        r_q <= w_num[15:0];
                        r_dcnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one restoring step per cycle; the quotient shifts in behind the dividend
                    if (w_trial >= {1'b0, r_w.life}) begin
                        r_rem <= 16'(w_trial - {1'b0, r_w.life});
                        r_q <= {r_q[14:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[15:0];
                        r_q <= {r_q[14:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_exp) begin
                        r_active[AW'(r_i)] <= 1'b0;
                    end
                    r_res.kind <= ppu_pkg::KIND_UPD;
                    r_res.slot <= r_i[SW-1:0];
                    r_res.accepted <= 1'b0;
                    r_res.out_x <= r_w.pos_x;
                    r_res.out_y <= r_w.pos_y;
                    r_res.out_z <= r_w.pos_z;
                    r_res.out_scale <= r_q;
                    r_res.expired <= w_exp;
                    r_res.last <= !w_later;
                    r_any <= 1'b1;
                    r_i <= r_i + 6'd1;
                    r_nxt <= S_TSCAN;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_out <= r_res;
                        r_state <= r_nxt;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {1'b0, r_out.expired, r_out.out_scale, r_out.out_z, r_out.out_y,
                            r_out.out_x, r_out.accepted, r_out.slot};

endmodule
`default_nettype wire

// ===== hdl/ppu_checker.sv =====
// Port-level assertions for the particle pool update core, with its bind.
`default_nettype none
module ppu_port_checks (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [119:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ppu_pkg::KIND_EMIT |-> m_axis_tlast)
        else $error("emit acknowledge without last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ppu_pkg::KIND_EMPTY |-> m_axis_tdata == '0 && m_axis_tlast)
        else $error("empty result carries data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a tick");

endmodule

bind particle_pool_update_core ppu_port_checks u_ppu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
